@@ rtl/rpp_pkg.sv @@
// shared types and constants for the point rotate and project core
package rpp_pkg;

    // fixed field widths
    localparam int COORD_W      = 16;
    localparam int PIXEL_W      = 16;
    localparam int SCALE_W      = 8;
    localparam int STEP_W       = 14;
    localparam int ORIGIN_W     = 12;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 16;

    // sine samples are q15, one is 32768
    localparam int SIN_ONE_BITS = 15;
    localparam int SAMPLE_W     = 16;

    // quotient bits produced by the divider
    localparam int QUOT_W       = 16;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    // register indexes
    localparam t_cfg_index CFG_SCALE      = 8'd0;
    localparam t_cfg_index CFG_ANGLE_STEP = 8'd1;
    localparam t_cfg_index CFG_ORIGIN_X   = 8'd2;
    localparam t_cfg_index CFG_ORIGIN_Y   = 8'd3;

endpackage

@@ rtl/rpp_sine_rom.sv @@
// quarter-wave sine rom, two registered read ports
module rpp_sine_rom #(
    parameter int DEPTH = 1024,
    parameter int AW    = 11
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [AW-1:0]                i_addr_a,
    input  logic [AW-1:0]                i_addr_b,
    output logic [rpp_pkg::SAMPLE_W-1:0] o_data_a,
    output logic [rpp_pkg::SAMPLE_W-1:0] o_data_b
);
    import rpp_pkg::*;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // (2k)(2k+1) divisors of the series terms
    localparam longint TAYLOR_DIV [1:7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                            64'sd110, 64'sd156, 64'sd210};

    typedef logic [SAMPLE_W-1:0] t_rom [DEPTH+1];

    // q30 taylor series through x^15, rounded to q15 and capped at one
    function automatic t_rom build_rom();
        t_rom   rom;
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        for (int i = 0; i <= DEPTH; i++) begin
            x    = (HALF_PI_Q30 * longint'(i)) / DEPTH;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >>> 30) / TAYLOR_DIV[k];
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + (longint'(1) <<< 14)) >>> 15;
            if (r > (longint'(1) <<< SIN_ONE_BITS)) begin
                r = longint'(1) <<< SIN_ONE_BITS;
            end
            rom[i] = SAMPLE_W'(r);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data_a <= SINE_ROM[i_addr_a];
            o_data_b <= SINE_ROM[i_addr_b];
        end
    end

endmodule

@@ rtl/rpp_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, signed 16-bit saturation
module rpp_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 36
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [NUM_W-1:0]     i_num,
    input  logic signed [DEN_W-1:0]     i_den,
    output logic signed [rpp_pkg::PIXEL_W-1:0] o_quot
);
    import rpp_pkg::*;

    localparam int WIDE = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;
    localparam int RW   = WIDE + 1;
    localparam int NST  = QUOT_W + 1;

    logic [RW-1:0]     r_rem [NST];
    logic [RW-1:0]     r_div [NST];
    logic [QUOT_W-1:0] r_q   [NST];
    logic              r_neg [NST];
    logic              r_sat [NST];

    logic [NUM_W-1:0]  w_mag;
    logic [RW-1:0]     w_mag_ext;
    logic [RW-1:0]     w_den_ext;

    // magnitude of the numerator, den is positive whenever the result is used
    assign w_mag     = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_mag_ext = RW'(w_mag);
    assign w_den_ext = RW'(i_den[DEN_W-2:0]);

    // first stage: overflow check against den scaled by 2^16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_mag_ext;
            r_div[0] <= w_den_ext;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[NUM_W-1];
            r_sat[0] <= w_mag_ext >= (w_den_ext << QUOT_W);
        end
    end

    // one trial subtract per stage, msb first
    for (genvar j = 1; j < NST; j++) begin : g_stage
        localparam int SH = QUOT_W - j;
        logic [RW-1:0] w_trial;
        logic          w_ge;
        assign w_trial = r_div[j-1] << SH;
        assign w_ge    = r_rem[j-1] >= w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? (r_rem[j-1] - w_trial) : r_rem[j-1];
                r_div[j] <= r_div[j-1];
                r_q[j]   <= {r_q[j-1][QUOT_W-2:0], w_ge};
                r_neg[j] <= r_neg[j-1];
                r_sat[j] <= r_sat[j-1];
            end
        end
    end

    // sign and saturate
    localparam logic [QUOT_W-1:0] POS_MAX = QUOT_W'((1 << (PIXEL_W - 1)) - 1);
    localparam logic [QUOT_W-1:0] NEG_MAX = QUOT_W'(1 << (PIXEL_W - 1));

    always_comb begin
        if (r_neg[NST-1]) begin
            if (r_sat[NST-1] || (r_q[NST-1] > NEG_MAX)) begin
                o_quot = $signed(NEG_MAX);
            end else begin
                o_quot = $signed(PIXEL_W'(-r_q[NST-1]));
            end
        end else begin
            if (r_sat[NST-1] || (r_q[NST-1] > POS_MAX)) begin
                o_quot = $signed(POS_MAX);
            end else begin
                o_quot = $signed(r_q[NST-1]);
            end
        end
    end

endmodule

@@ rtl/point_rotate_project_core.sv @@
// top level: y-axis rotation and perspective projection pipeline
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_action, i_point_x, i_point_y, i_point_z
//  result    out        o_valid / i_stall         o_pixel_x, o_pixel_y, o_behind_viewer
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while no result is held; a point's result reaches the output register
// through five arithmetic stages (the first loaded on the transfer edge), 17 divider
// stages and one output register
// a tick updates the phase at its transfer and produces no result
// a held result freezes the whole pipeline, so input stalls exactly then
// synchronous active-low reset clears valids, phase and origins and sets scale 80, step 104
module point_rotate_project_core #(
    parameter int COORD_FRAC_BITS  = 12,
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int VIEW_DISTANCE    = 50
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_action,
    input  logic signed [rpp_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [rpp_pkg::COORD_W-1:0]  i_point_y,
    input  logic signed [rpp_pkg::COORD_W-1:0]  i_point_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [rpp_pkg::PIXEL_W-1:0]  o_pixel_x,
    output logic signed [rpp_pkg::PIXEL_W-1:0]  o_pixel_y,
    output logic                                o_behind_viewer,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  rpp_pkg::t_cfg_index                 i_cfg_index,
    input  logic [rpp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rpp_pkg::*;

    // widths
    localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IPW    = PHASE_BITS - 2 + AW;
    localparam int VD_W   = $clog2(VIEW_DISTANCE + 1);
    localparam int SV_W   = SCALE_W + VD_W;
    localparam int PRD_W  = COORD_W + SAMPLE_W + 1;
    localparam int ROT_W  = PRD_W + 1;
    localparam int DEN_B  = VD_W + COORD_FRAC_BITS + SIN_ONE_BITS;
    localparam int DEN_W  = ((DEN_B > ROT_W) ? DEN_B : ROT_W) + 2;
    localparam int PX_W   = ROT_W + SV_W + 1;
    localparam int PY_W   = COORD_W + SV_W + 1;
    localparam int OD_W   = ORIGIN_W + 1 + DEN_W;
    localparam int PYS_W  = PY_W + SIN_ONE_BITS;
    localparam int M1_W   = (PX_W > OD_W) ? PX_W : OD_W;
    localparam int NUM_W  = ((M1_W > PYS_W) ? M1_W : PYS_W) + 1;
    localparam int DSTG   = QUOT_W + 1;
    localparam logic signed [DEN_W-1:0] VD_TERM =
        DEN_W'(VIEW_DISTANCE) << (COORD_FRAC_BITS + SIN_ONE_BITS);

    // config registers and phase
    logic [SCALE_W-1:0]    r_scale;
    logic [STEP_W-1:0]     r_step;
    logic [ORIGIN_W-1:0]   r_origin_x;
    logic [ORIGIN_W-1:0]   r_origin_y;
    logic [SV_W-1:0]       r_sv;
    logic [PHASE_BITS-1:0] r_phase;

    logic w_adv;
    logic w_take;
    logic w_tick;
    logic w_point;

    assign o_cfg_ready = 1'b1;
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;
    assign w_take  = i_valid && w_adv;
    assign w_tick  = w_take && !i_action;
    assign w_point = w_take && i_action;

    // config writes and phase update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_W'(80);
            r_step     <= STEP_W'(104);
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_sv       <= '0;
            r_phase    <= '0;
        end else begin
            r_sv <= SV_W'(r_scale * SV_W'(VIEW_DISTANCE));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCALE:      r_scale    <= i_cfg_data[SCALE_W-1:0];
                    CFG_ANGLE_STEP: r_step     <= i_cfg_data[STEP_W-1:0];
                    CFG_ORIGIN_X:   r_origin_x <= i_cfg_data[ORIGIN_W-1:0];
                    CFG_ORIGIN_Y:   r_origin_y <= i_cfg_data[ORIGIN_W-1:0];
                    default: ;
                endcase
            end
            if (w_tick) begin
                r_phase <= r_phase + PHASE_BITS'(r_step);
            end
        end
    end

    // table address from the phase
    logic [1:0]            w_quad;
    logic [IPW-1:0]        w_iprod;
    logic [AW-1:0]         w_idx;
    logic [AW-1:0]         w_idx_c;
    logic [AW-1:0]         w_addr_s;
    logic [AW-1:0]         w_addr_c;

    assign w_quad   = r_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign w_iprod  = IPW'(r_phase[PHASE_BITS-3:0]) * IPW'(SINE_TABLE_DEPTH);
    assign w_idx    = w_iprod[PHASE_BITS-2 +: AW];
    assign w_idx_c  = AW'(SINE_TABLE_DEPTH) - w_idx;
    assign w_addr_s = w_quad[0] ? w_idx_c : w_idx;
    assign w_addr_c = w_quad[0] ? w_idx : w_idx_c;

    // stage 1: table read, point capture
    logic                       r1_vld;
    logic signed [COORD_W-1:0]  r1_x, r1_y, r1_z;
    logic                       r1_neg_s, r1_neg_c;
    logic [SAMPLE_W-1:0]        w_s_mag, w_c_mag;

    rpp_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH),
        .AW    (AW)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_addr_a (w_addr_s),
        .i_addr_b (w_addr_c),
        .o_data_a (w_s_mag),
        .o_data_b (w_c_mag)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_x     <= i_point_x;
            r1_y     <= i_point_y;
            r1_z     <= i_point_z;
            r1_neg_s <= w_quad[1];
            r1_neg_c <= w_quad[1] ^ w_quad[0];
        end
    end

    // stage 2: rotation products
    logic signed [SAMPLE_W:0]   w_s, w_c;
    logic                       r2_vld;
    logic signed [PRD_W-1:0]    r2_xc, r2_zs, r2_xs, r2_zc;
    logic signed [COORD_W-1:0]  r2_y;

    assign w_s = r1_neg_s ? -$signed({1'b0, w_s_mag}) : $signed({1'b0, w_s_mag});
    assign w_c = r1_neg_c ? -$signed({1'b0, w_c_mag}) : $signed({1'b0, w_c_mag});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_xc <= r1_x * w_c;
            r2_zs <= r1_z * w_s;
            r2_xs <= r1_x * w_s;
            r2_zc <= r1_z * w_c;
            r2_y  <= r1_y;
        end
    end

    // stage 3: rotated x, depth denominator, behind check
    logic signed [DEN_W-1:0]    w_den;
    logic                       r3_vld, r3_beh;
    logic signed [ROT_W-1:0]    r3_rx;
    logic signed [DEN_W-1:0]    r3_den;
    logic signed [COORD_W-1:0]  r3_y;

    assign w_den = VD_TERM + DEN_W'(r2_xs) + DEN_W'(r2_zc);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_rx  <= ROT_W'(r2_xc) - ROT_W'(r2_zs);
            r3_den <= w_den;
            r3_beh <= (w_den <= 0);
            r3_y   <= r2_y;
        end
    end

    // stage 4: scale and origin products
    logic signed [SV_W:0]       w_sv;
    logic signed [ORIGIN_W:0]   w_ox, w_oy;
    logic signed [PY_W-1:0]     w_yprod;
    logic                       r4_vld, r4_beh;
    logic signed [PX_W-1:0]     r4_px;
    logic signed [PY_W-1:0]     r4_py;
    logic signed [OD_W-1:0]     r4_oxd, r4_oyd;
    logic signed [DEN_W-1:0]    r4_den;

    assign w_sv    = $signed({1'b0, r_sv});
    assign w_ox    = $signed({1'b0, r_origin_x});
    assign w_oy    = $signed({1'b0, r_origin_y});
    assign w_yprod = r3_y * w_sv;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_px  <= r3_rx * w_sv;
            r4_py  <= -w_yprod;
            r4_oxd <= w_ox * r3_den;
            r4_oyd <= w_oy * r3_den;
            r4_den <= r3_den;
            r4_beh <= r3_beh;
        end
    end

    // stage 5: numerators
    logic                       r5_vld, r5_beh;
    logic signed [NUM_W-1:0]    r5_nx, r5_ny;
    logic signed [DEN_W-1:0]    r5_den;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_nx  <= NUM_W'(r4_px) + NUM_W'(r4_oxd);
            r5_ny  <= (NUM_W'(r4_py) <<< SIN_ONE_BITS) + NUM_W'(r4_oyd);
            r5_den <= r4_den;
            r5_beh <= r4_beh;
        end
    end

    // dividers, one per pixel axis
    logic signed [PIXEL_W-1:0] w_qx, w_qy;

    rpp_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r5_nx),
        .i_den  (r5_den),
        .o_quot (w_qx)
    );

    rpp_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r5_ny),
        .i_den  (r5_den),
        .o_quot (w_qy)
    );

    // flags riding alongside the dividers
    logic r_dvld [DSTG];
    logic r_dbeh [DSTG];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dbeh[0] <= r5_beh;
            for (int j = 1; j < DSTG; j++) begin
                r_dbeh[j] <= r_dbeh[j-1];
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r4_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            for (int j = 0; j < DSTG; j++) begin
                r_dvld[j] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= w_point;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r_dvld[0] <= r5_vld;
            for (int j = 1; j < DSTG; j++) begin
                r_dvld[j] <= r_dvld[j-1];
            end
            o_valid   <= r_dvld[DSTG-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_behind_viewer <= r_dbeh[DSTG-1];
            o_pixel_x       <= r_dbeh[DSTG-1] ? '0 : w_qx;
            o_pixel_y       <= r_dbeh[DSTG-1] ? '0 : w_qy;
        end
    end

    // checks
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_behind_viewer) |-> (o_pixel_x == 0 && o_pixel_y == 0))
        else $error("behind-viewer result with nonzero pixels");

    a_tick_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> !r1_vld)
        else $error("tick entered the pipeline");

    a_tick_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> (r_phase == PHASE_BITS'($past(r_phase) + PHASE_BITS'($past(r_step)))))
        else $error("phase did not advance by the step");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r5_vld) && $stable(r1_vld)))
        else $error("pipeline moved while the result was held");

endmodule
